// ===== design/xte_pkg.sv =====
// Shared constants and helpers for the XML text escaping UTF-8 encoder.
`default_nettype none
package xte_pkg;

    localparam int unsigned UNIT_W     = 16;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned MAX_BYTES  = 6;
    localparam int unsigned CNT_W      = 3;
    localparam int unsigned PEND_W     = 11;

    localparam logic [UNIT_W-1:0] HIGH_SURR_MIN = 16'hD800;
    localparam logic [UNIT_W-1:0] HIGH_SURR_MAX = 16'hDBFF;
    localparam logic [UNIT_W-1:0] LOW_SURR_MIN  = 16'hDC00;
    localparam logic [UNIT_W-1:0] LOW_SURR_MAX  = 16'hDFFF;
    localparam logic [UNIT_W-1:0] CTRL_LIMIT    = 16'h0020;
    localparam logic [UNIT_W-1:0] CHAR_TAB      = 16'h0009;
    localparam logic [UNIT_W-1:0] CHAR_LF       = 16'h000A;
    localparam logic [UNIT_W-1:0] CHAR_AMP      = 16'h0026;
    localparam logic [UNIT_W-1:0] CHAR_LT       = 16'h003C;
    localparam logic [UNIT_W-1:0] CHAR_GT       = 16'h003E;
    localparam logic [UNIT_W-1:0] CHAR_QUOT     = 16'h0022;
    localparam logic [BYTE_W-1:0] SPACE_BYTE    = 8'h20;

    typedef logic [MAX_BYTES*BYTE_W-1:0] byte_seq_t;

    // Entity strings, first byte in the lowest bits.
    localparam byte_seq_t ENT_AMP  = 48'h00_3B_70_6D_61_26; // "&amp;"
    localparam byte_seq_t ENT_LT   = 48'h00_00_3B_74_6C_26; // "&lt;"
    localparam byte_seq_t ENT_GT   = 48'h00_00_3B_74_67_26; // "&gt;"
    localparam byte_seq_t ENT_QUOT = 48'h3B_74_6F_75_71_26; // "&quot;"

    // U+FFFD as UTF-8, first byte in the lowest bits.
    localparam logic [3*BYTE_W-1:0] REPL_SEQ = 24'hBD_BF_EF;

    typedef struct packed {
        byte_seq_t        seq;
        logic [CNT_W-1:0] len;
    } enc_t;

    // UTF-8 encoding of a code point in the basic plane (one to three bytes).
    function automatic enc_t encode_bmp(input logic [UNIT_W-1:0] cp);
        enc_t r;
        r.seq = '0;
        if (cp < 16'h0080) begin
            r.seq[7:0] = cp[7:0];
            r.len      = CNT_W'(1);
        end else if (cp < 16'h0800) begin
            r.seq[7:0]  = {3'b110, cp[10:6]};
            r.seq[15:8] = {2'b10, cp[5:0]};
            r.len       = CNT_W'(2);
        end else begin
            r.seq[7:0]   = {4'b1110, cp[15:12]};
            r.seq[15:8]  = {2'b10, cp[11:6]};
            r.seq[23:16] = {2'b10, cp[5:0]};
            r.len        = CNT_W'(3);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/xml_text_escape_utf8_unit.sv =====
// Top level: UTF-16 to UTF-8 encoder with XML character-data escaping.
//
// Usage: UTF-16 code units enter on the s_ channel, one unit per beat, with
// s_tlast marking the last unit of a string. Escaped UTF-8 bytes leave on the
// m_ channel, one byte per beat, with m_tlast set on the final byte that an
// input unit produces. A high surrogate that is not the last unit produces no
// bytes; it is held and joined with the following low surrogate.
// Latency: the first byte of a unit appears on m_ the cycle after the unit is accepted.
// Throughput: one unit per cycle while each unit yields one byte and m_tready
// stays high; a unit that yields more bytes occupies the output byte buffer,
// and the next unit is taken in the cycle its final byte leaves. The limit is
// the single output byte lane.
// Reset: aresetn low for one clock edge empties the byte buffer and drops any
// held high surrogate.
// Stalls: when m_tready is low the current byte holds steady and s_tready
// is low while any byte is buffered, as it is whenever more than one is left.
`default_nettype none
module xml_text_escape_utf8_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // [15:0] code_unit
    input  wire logic        s_tlast,  // end_of_text
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,  // [7:0] out_byte
    output logic             m_tlast   // last_of_run
);

    localparam int unsigned BW = xte_pkg::BYTE_W;
    localparam int unsigned CW = xte_pkg::CNT_W;

    xte_pkg::byte_seq_t       buf_reg, buf_next;
    logic [CW-1:0]            rem_reg, rem_next;
    logic [xte_pkg::PEND_W-1:0] pend_reg, pend_next;

    logic                     accept;
    logic                     held, is_high, is_low, is_ent, is_ctrl;
    logic [15:0]              u;
    logic [20:0]              cp_sup;
    xte_pkg::enc_t            sfx, bmp;
    logic                     add_repl;
    xte_pkg::byte_seq_t       seq;
    logic [CW-1:0]            seq_len;

    assign u        = s_tdata;
    assign held     = pend_reg[10];
    assign is_high  = (u >= xte_pkg::HIGH_SURR_MIN) && (u <= xte_pkg::HIGH_SURR_MAX);
    assign is_low   = (u >= xte_pkg::LOW_SURR_MIN) && (u <= xte_pkg::LOW_SURR_MAX);
    assign is_ent   = (u == xte_pkg::CHAR_AMP) || (u == xte_pkg::CHAR_LT)
                   || (u == xte_pkg::CHAR_GT) || (u == xte_pkg::CHAR_QUOT);
    assign is_ctrl  = (u < xte_pkg::CTRL_LIMIT) && (u != xte_pkg::CHAR_TAB)
                   && (u != xte_pkg::CHAR_LF);
    assign bmp      = xte_pkg::encode_bmp(u);
    assign cp_sup   = 21'h10000 + {1'b0, pend_reg[9:0], u[9:0]};

    // Bytes caused by the unit itself, ignoring any orphaned high surrogate.
    always_comb begin
        sfx.seq = '0;
        sfx.len = '0;
        if (held && is_low) begin
            sfx.seq[7:0]   = {5'b11110, cp_sup[20:18]};
            sfx.seq[15:8]  = {2'b10, cp_sup[17:12]};
            sfx.seq[23:16] = {2'b10, cp_sup[11:6]};
            sfx.seq[31:24] = {2'b10, cp_sup[5:0]};
            sfx.len        = CW'(4);
        end else if (u == xte_pkg::CHAR_AMP) begin
            sfx.seq = xte_pkg::ENT_AMP;
            sfx.len = CW'(5);
        end else if (u == xte_pkg::CHAR_LT) begin
            sfx.seq = xte_pkg::ENT_LT;
            sfx.len = CW'(4);
        end else if (u == xte_pkg::CHAR_GT) begin
            sfx.seq = xte_pkg::ENT_GT;
            sfx.len = CW'(4);
        end else if (u == xte_pkg::CHAR_QUOT) begin
            sfx.seq = xte_pkg::ENT_QUOT;
            sfx.len = CW'(6);
        end else if (is_ctrl) begin
            sfx.seq[7:0] = xte_pkg::SPACE_BYTE;
            sfx.len      = CW'(1);
        end else if (is_high) begin
            if (s_tlast) begin
                sfx.seq[23:0] = xte_pkg::REPL_SEQ;
                sfx.len       = CW'(3);
            end
        end else if (is_low) begin
            sfx.seq[23:0] = xte_pkg::REPL_SEQ;
            sfx.len       = CW'(3);
        end else begin
            sfx = bmp;
        end
    end

    // An orphaned high surrogate becomes U+FFFD, except before an entity,
    // where it is dropped so the run still fits six bytes.
    assign add_repl = held && !is_low && !is_ent;

    always_comb begin
        if (add_repl) begin
            seq     = {sfx.seq[3*BW-1:0], xte_pkg::REPL_SEQ};
            seq_len = sfx.len + CW'(3);
        end else begin
            seq     = sfx.seq;
            seq_len = sfx.len;
        end
    end

    assign s_tready = (rem_reg == '0) || ((rem_reg == CW'(1)) && m_tready);
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = (rem_reg != '0);
    assign m_tdata  = buf_reg[BW-1:0];
    assign m_tlast  = (rem_reg == CW'(1));

    always_comb begin
        buf_next  = buf_reg;
        rem_next  = rem_reg;
        pend_next = pend_reg;
        if (accept) begin
            buf_next  = seq;
            rem_next  = seq_len;
            pend_next = (is_high && !s_tlast) ? {1'b1, u[9:0]} : '0;
        end else if (m_tvalid && m_tready) begin
            buf_next = buf_reg >> BW;
            rem_next = rem_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
        if (!aresetn) begin
            rem_reg  <= '0;
            pend_reg <= '0;
        end else begin
            rem_reg  <= rem_next;
            pend_reg <= pend_next;
        end
    end

endmodule
`default_nettype wire

// ===== test/tb_xml_text_escape_utf8_unit.sv =====
// Testbench for the XML text escaping UTF-8 encoder, checking directed and random streams against a predictor.
module tb_xml_text_escape_utf8_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_UNITS = 200;
    localparam int unsigned TAIL_UNITS   = 40;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned MAX_PRINTED  = 40;
    localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;

    typedef enum int {
        KIND_ASCII, KIND_ENTITY, KIND_CTRL, KIND_TWO_BYTE, KIND_THREE_BYTE,
        KIND_PAIR, KIND_LONE_HIGH, KIND_LONE_LOW, KIND_ANY
    } unit_kind_t;

    typedef struct {
        logic [15:0] unit;
        logic        eot;
    } text_unit_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } utf8_beat_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    text_unit_t  unit_feed[$];
    utf8_beat_t  byte_expect[$];
    logic [7:0]  run_bytes[$];

    // Bit 10 flags a held high surrogate, bits 9..0 hold its payload.
    logic [10:0] held_high = '0;

    int unsigned mismatches    = 0;
    int unsigned cycle_count   = 0;
    int unsigned units_sent    = 0;
    int unsigned strings_sent  = 0;
    int unsigned bytes_checked = 0;
    int unsigned pairs_queued  = 0;
    int unsigned src_gap       = 0;
    int unsigned sink_gap      = 0;

    xml_text_escape_utf8_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    function automatic bit calm_phase();
        return unit_feed.size() < TAIL_UNITS;
    endfunction

    function automatic string entity_text(input logic [15:0] u);
        case (u)
            xte_pkg::CHAR_AMP:  return "&amp;";
            xte_pkg::CHAR_LT:   return "&lt;";
            xte_pkg::CHAR_GT:   return "&gt;";
            xte_pkg::CHAR_QUOT: return "&quot;";
            default:            return "";
        endcase
    endfunction

    task automatic put_byte(input logic [7:0] b);
        run_bytes.push_back(b);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            put_byte(s[i]);
        end
    endtask

    task automatic put_point(input logic [20:0] cp);
        if (cp < 21'h80) begin
            put_byte(cp[7:0]);
        end else if (cp < 21'h800) begin
            put_byte({3'b110, cp[10:6]});
            put_byte({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            put_byte({4'b1110, cp[15:12]});
            put_byte({2'b10, cp[11:6]});
            put_byte({2'b10, cp[5:0]});
        end else begin
            put_byte({5'b11110, cp[20:18]});
            put_byte({2'b10, cp[17:12]});
            put_byte({2'b10, cp[11:6]});
            put_byte({2'b10, cp[5:0]});
        end
    endtask

    // Works out the bytes one accepted unit causes and queues them as expected beats.
    task automatic predict_unit(input logic [15:0] u, input logic eot);
        logic        held;
        logic        is_high;
        logic        is_low;
        logic        is_ent;
        string       ent;
        logic [20:0] cp;
        utf8_beat_t  beat;
        run_bytes.delete();
        held    = held_high[10];
        is_high = (u >= xte_pkg::HIGH_SURR_MIN) && (u <= xte_pkg::HIGH_SURR_MAX);
        is_low  = (u >= xte_pkg::LOW_SURR_MIN) && (u <= xte_pkg::LOW_SURR_MAX);
        ent     = entity_text(u);
        is_ent  = (ent.len() != 0);
        if (held && is_low) begin
            cp = 21'h10000 + {1'b0, held_high[9:0], 10'b0} + {11'b0, u[9:0]};
            held_high = '0;
            put_point(cp);
        end else begin
            if (held) begin
                held_high = '0;
                // An orphan high surrogate in front of an entity is dropped silently.
                if (!is_ent) put_point(REPLACEMENT_CP);
            end
            if (is_ent) begin
                put_text(ent);
            end else if (u < xte_pkg::CTRL_LIMIT && u != xte_pkg::CHAR_TAB
                         && u != xte_pkg::CHAR_LF) begin
                put_byte(xte_pkg::SPACE_BYTE);
            end else if (is_high) begin
                if (eot) put_point(REPLACEMENT_CP);
                else held_high = {1'b1, u[9:0]};
            end else if (is_low) begin
                put_point(REPLACEMENT_CP);
            end else begin
                put_point({5'b0, u});
            end
        end
        for (int i = 0; i < run_bytes.size(); i++) begin
            beat.data = run_bytes[i];
            beat.last = (i == run_bytes.size() - 1);
            byte_expect.push_back(beat);
        end
    endtask

    task automatic add_unit(input logic [15:0] u, input logic eot);
        text_unit_t t;
        t.unit = u;
        t.eot  = eot;
        unit_feed.push_back(t);
        if (eot) strings_sent++;
    endtask

    task automatic add_random_string();
        int unsigned len;
        int unsigned r;
        logic        last;
        logic [15:0] u;
        unit_kind_t  kind;
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) begin
            last = (i == len - 1);
            r = $urandom_range(0, 19);
            if (r <= 5)       kind = KIND_ASCII;
            else if (r <= 7)  kind = KIND_ENTITY;
            else if (r <= 9)  kind = KIND_CTRL;
            else if (r <= 11) kind = KIND_TWO_BYTE;
            else if (r <= 13) kind = KIND_THREE_BYTE;
            else if (r <= 16) kind = KIND_PAIR;
            else if (r == 17) kind = KIND_LONE_HIGH;
            else if (r == 18) kind = KIND_LONE_LOW;
            else              kind = KIND_ANY;
            case (kind)
                KIND_ASCII: u = 16'($urandom_range(16'h20, 16'h7E));
                KIND_ENTITY: begin
                    case ($urandom_range(0, 3))
                        0:       u = xte_pkg::CHAR_AMP;
                        1:       u = xte_pkg::CHAR_LT;
                        2:       u = xte_pkg::CHAR_GT;
                        default: u = xte_pkg::CHAR_QUOT;
                    endcase
                end
                KIND_CTRL:     u = 16'($urandom_range(0, 16'h1F));
                KIND_TWO_BYTE: u = 16'($urandom_range(16'h80, 16'h7FF));
                KIND_THREE_BYTE: begin
                    // Skip over the surrogate range.
                    u = 16'($urandom_range(16'h800, 16'hF7FF));
                    if (u >= xte_pkg::HIGH_SURR_MIN) u = u + 16'h800;
                end
                KIND_PAIR: begin
                    add_unit(16'($urandom_range(xte_pkg::HIGH_SURR_MIN,
                                                xte_pkg::HIGH_SURR_MAX)), 1'b0);
                    pairs_queued++;
                    u = 16'($urandom_range(xte_pkg::LOW_SURR_MIN, xte_pkg::LOW_SURR_MAX));
                end
                KIND_LONE_HIGH: begin
                    u = 16'($urandom_range(xte_pkg::HIGH_SURR_MIN, xte_pkg::HIGH_SURR_MAX));
                end
                KIND_LONE_LOW: begin
                    u = 16'($urandom_range(xte_pkg::LOW_SURR_MIN, xte_pkg::LOW_SURR_MAX));
                end
                default:        u = 16'($urandom_range(0, 16'hFFFF));
            endcase
            add_unit(u, last);
        end
    endtask

    // Source side: holds a beat until it is taken, then offers the next one or idles.
    always @(posedge aclk) begin : drive_proc
        logic        nv;
        logic [15:0] nd;
        logic        nl;
        text_unit_t  t;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !s_tready)) begin
            nv = 1'b0;
            nd = s_tdata;
            nl = s_tlast;
            if (s_tvalid) begin
                predict_unit(s_tdata, s_tlast);
                units_sent++;
            end
            if (src_gap > 0) begin
                src_gap--;
            end else if (unit_feed.size() > 0) begin
                if (!calm_phase() && $urandom_range(0, 9) == 0) begin
                    src_gap = $urandom_range(0, 16);
                end else begin
                    t  = unit_feed.pop_front();
                    nv = 1'b1;
                    nd = t.unit;
                    nl = t.eot;
                end
            end
            s_tvalid <= nv;
            s_tdata  <= nd;
            s_tlast  <= nl;
        end
    end

    // Sink side: checks every accepted byte beat and stalls in bursts.
    always @(posedge aclk) begin : monitor_proc
        logic       nr;
        utf8_beat_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                bytes_checked++;
                if (byte_expect.size() == 0) begin
                    flag_mismatch($sformatf("unexpected byte %02h last=%0b", m_tdata, m_tlast));
                end else begin
                    want = byte_expect.pop_front();
                    if (m_tdata !== want.data) begin
                        flag_mismatch($sformatf("out_byte %02h, expected %02h",
                                                m_tdata, want.data));
                    end
                    if (m_tlast !== want.last) begin
                        flag_mismatch($sformatf("last_of_run %0b, expected %0b on byte %02h",
                                                m_tlast, want.last, want.data));
                    end
                end
            end
            nr = 1'b1;
            if (sink_gap > 0) begin
                sink_gap--;
                nr = 1'b0;
            end else if (!calm_phase() && $urandom_range(0, 9) == 0) begin
                sink_gap = $urandom_range(0, 16);
                nr = 1'b0;
            end
            m_tready <= nr;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int unsigned base;
        // Extremes, controls, entities, encoding boundaries and surrogate corners.
        add_unit(16'h0041, 1'b0);
        add_unit(xte_pkg::CHAR_TAB, 1'b0);
        add_unit(xte_pkg::CHAR_LF, 1'b0);
        add_unit(16'h0000, 1'b0);
        add_unit(16'h001F, 1'b0);
        add_unit(16'h000D, 1'b0);
        add_unit(xte_pkg::CHAR_AMP, 1'b0);
        add_unit(xte_pkg::CHAR_LT, 1'b0);
        add_unit(xte_pkg::CHAR_GT, 1'b0);
        add_unit(xte_pkg::CHAR_QUOT, 1'b0);
        add_unit(16'h007F, 1'b0);
        add_unit(16'h0080, 1'b0);
        add_unit(16'h07FF, 1'b0);
        add_unit(16'h0800, 1'b0);
        add_unit(16'hFFFF, 1'b0);
        add_unit(xte_pkg::HIGH_SURR_MIN, 1'b0);
        add_unit(xte_pkg::LOW_SURR_MIN, 1'b0);
        add_unit(xte_pkg::HIGH_SURR_MAX, 1'b0);
        add_unit(xte_pkg::LOW_SURR_MAX, 1'b0);
        // A high surrogate followed by a plain letter.
        add_unit(16'hD834, 1'b0);
        add_unit(16'h0042, 1'b0);
        // A high surrogate followed by an escaped character.
        add_unit(16'hDA00, 1'b0);
        add_unit(xte_pkg::CHAR_QUOT, 1'b0);
        // A high surrogate that ends the text.
        add_unit(16'hDBC0, 1'b1);
        add_unit(xte_pkg::LOW_SURR_MIN, 1'b0);
        // Two highs in a row, then a low that pairs with the second.
        add_unit(16'hD801, 1'b0);
        add_unit(16'hD802, 1'b0);
        add_unit(16'hDC05, 1'b0);
        add_unit(16'h0020, 1'b1);
        pairs_queued += 3;

        base = unit_feed.size();
        while (unit_feed.size() - base < RANDOM_UNITS) begin
            add_random_string();
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (unit_feed.size() > 0 || s_tvalid || byte_expect.size() > 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (byte_expect.size() > 0) begin
            flag_mismatch($sformatf("%0d expected bytes never arrived", byte_expect.size()));
        end
        $display("Sent %0d code units in %0d strings, %0d surrogate pairs among them.",
                 units_sent, strings_sent, pairs_queued);
        $display("Checked %0d output bytes with %0d mismatches.", bytes_checked, mismatches);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/xte_pkg.sv
design/xml_text_escape_utf8_unit.sv
test/tb_xml_text_escape_utf8_unit.sv
